// ----- sv/button_debounce_press_classifier_defines.svh -----
// Assertion macros shared by the button debounce press classifier RTL.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising clock edge outside reset.
`define BDPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication from a trigger condition to a property.
`define BDPC_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
`else
`define BDPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDPC_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

// ----- sv/bdpc_pkg.sv -----
// Types, constants and helper functions for the button debounce press classifier.
package bdpc_pkg;

  localparam int TimerBits = 16;
  localparam int CfgBits   = 16;
  localparam int HoldBits  = 16;
  localparam int CmpBits   = (TimerBits > CfgBits) ? TimerBits : CfgBits;
  localparam int CfgIdxBits = 2;

  typedef logic [TimerBits-1:0]  timer_t;
  typedef logic [CfgBits-1:0]    cfg_t;
  typedef logic [HoldBits-1:0]   hold_t;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgDebounce   = 2'd0;
  localparam cfg_idx_t CfgShortLimit = 2'd1;
  localparam cfg_idx_t CfgLongLimit  = 2'd2;

  localparam cfg_t DebounceReset   = 16'd50;
  localparam cfg_t ShortLimitReset = 16'd500;
  localparam cfg_t LongLimitReset  = 16'd1000;

  localparam hold_t HoldMax = '1;

  typedef struct packed {
    logic  press_event;
    logic  release_event;
    logic  short_event;
    logic  long_event;
    logic  is_held;
    hold_t hold_ticks;
  } res_t;

  // Increment that stops at the all-ones value.
  function automatic timer_t sat_inc(timer_t v);
    if (v == '1) begin
      return v;
    end
    return timer_t'(v + 1'b1);
  endfunction

  // Compare a timer against a register value in a common width.
  function automatic logic timer_ge(timer_t t, cfg_t c);
    logic [CmpBits-1:0] tw;
    logic [CmpBits-1:0] cw;
    tw = CmpBits'(t);
    cw = CmpBits'(c);
    return tw >= cw;
  endfunction

  // Fit a timer into the reported hold width, saturating if it is wider.
  function automatic hold_t clamp_hold(timer_t v);
    logic [CmpBits-1:0] w;
    w = CmpBits'(v);
    if (w > CmpBits'(HoldMax)) begin
      return HoldMax;
    end
    return HoldBits'(w);
  endfunction

endpackage

// ----- sv/button_debounce_press_classifier.sv -----
// Output: a tick accepted at an edge is registered into the output register at that edge,
// or into the skid register if the output side stalls. Throughput: one tick per clock
// cycle while in_stall_o is low; the skid register takes one more tick once the output stalls.
// All per-tick work is one pass of counter, compare and select logic.
// Reset: asynchronous, active low; state counters clear, the previous level reads as
// released, and the three registers return to 50, 500 and 1000 ticks.
`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bdpc_pkg::cfg_idx_t  cfg_idx_i,
  input  bdpc_pkg::cfg_t      cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                raw_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                press_event_o,
  output logic                release_event_o,
  output logic                short_event_o,
  output logic                long_event_o,
  output logic                is_held_o,
  output bdpc_pkg::hold_t     hold_ticks_o
);
  import bdpc_pkg::*;

  cfg_t   debounce_q, short_limit_q, long_limit_q;

  logic   prev_raw_q, prev_raw_d;
  timer_t stable_q, stable_d;
  logic   held_q, held_d;
  timer_t hold_q, hold_d;
  logic   long_done_q, long_done_d;

  res_t   res_d;
  res_t   out_q, skid_q;
  logic   out_valid_q, skid_valid_q;

  logic   accept_in;
  logic   out_free;
  timer_t hold_inc;
  logic   settled;
  logic   pressed;

  assign in_stall_o = skid_valid_q;
  assign accept_in  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceReset;
      short_limit_q <= ShortLimitReset;
      long_limit_q  <= LongLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDebounce:   debounce_q    <= cfg_data_i;
        CfgShortLimit: short_limit_q <= cfg_data_i;
        CfgLongLimit:  long_limit_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Per-tick update of the debounce and hold state.
  always_comb begin
    hold_inc = held_q ? sat_inc(hold_q) : hold_q;
    stable_d = (raw_level_i != prev_raw_q) ? '0 : sat_inc(stable_q);
    prev_raw_d = raw_level_i;
    settled = timer_ge(stable_d, debounce_q);
    pressed = !raw_level_i;

    held_d      = held_q;
    hold_d      = hold_inc;
    long_done_d = long_done_q;
    res_d       = '0;

    if (settled) begin
      if (pressed && !held_q) begin
        held_d            = 1'b1;
        hold_d            = '0;
        long_done_d       = 1'b0;
        res_d.press_event = 1'b1;
      end else if (!pressed && held_q) begin
        held_d              = 1'b0;
        res_d.short_event   = !long_done_q && !timer_ge(hold_inc, short_limit_q);
        res_d.release_event = 1'b1;
        hold_d              = '0;
      end else if (pressed && !long_done_q) begin
        if (timer_ge(hold_inc, long_limit_q)) begin
          long_done_d      = 1'b1;
          res_d.long_event = 1'b1;
        end
      end
    end

    res_d.is_held    = held_d;
    res_d.hold_ticks = held_d ? clamp_hold(hold_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= 1'b1;
      stable_q    <= '0;
      held_q      <= 1'b0;
      hold_q      <= '0;
      long_done_q <= 1'b0;
    end else if (accept_in) begin
      prev_raw_q  <= prev_raw_d;
      stable_q    <= stable_d;
      held_q      <= held_d;
      hold_q      <= hold_d;
      long_done_q <= long_done_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept_in) begin
        out_q <= res_d;
      end
    end else if (accept_in) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign press_event_o   = out_q.press_event;
  assign release_event_o = out_q.release_event;
  assign short_event_o   = out_q.short_event;
  assign long_event_o    = out_q.long_event;
  assign is_held_o       = out_q.is_held;
  assign hold_ticks_o    = out_q.hold_ticks;

  `BDPC_ASSERT(a_skid_behind_out, clk_i, rst_ni, !skid_valid_q || out_valid_q, "skid entry without output entry")
  `BDPC_ASSERT_IMP(a_no_press_and_release, clk_i, rst_ni, out_valid_q, !(out_q.press_event && out_q.release_event), "press and release in one result")
  `BDPC_ASSERT_IMP(a_short_needs_release, clk_i, rst_ni, out_valid_q && out_q.short_event, out_q.release_event, "short press without release")
  `BDPC_ASSERT_IMP(a_idle_hold_zero, clk_i, rst_ni, out_valid_q && !out_q.is_held, out_q.hold_ticks == '0, "hold count shown while released")
  `BDPC_ASSERT_IMP(a_long_sets_done, clk_i, rst_ni, accept_in && res_d.long_event, ##1 long_done_q, "long press did not mark the hold")

endmodule
